### hw/rtl/gcl_pkg.sv
package gcl_pkg;

	// Sizes of the stop table and of the gradient
	localparam int unsigned STOP_NUM = 6;
	localparam int unsigned MAX_RES  = 4096;
	localparam int unsigned CHAN_NUM = 4;
	localparam int unsigned CHAN_W   = 8;
	localparam int unsigned COLOR_W  = CHAN_NUM * CHAN_W;

	// Count holds STOP_NUM itself, index picks one of STOP_NUM stops
	localparam int unsigned CNT_W = $clog2(STOP_NUM + 1);
	localparam int unsigned IDX_W = $clog2(STOP_NUM);
	localparam int unsigned POS_W = 12;
	localparam int unsigned RES_W = 13;
	localparam int unsigned DEN_W = 12;
	// position * (stops - 1)
	localparam int unsigned SCL_W = DEN_W + IDX_W;
	// lo * (den - rem) + hi * rem stays below 2^20
	localparam int unsigned NUM_W = CHAN_W + DEN_W;

	// APB side
	localparam int unsigned CFG_AW = 5;
	localparam int unsigned CFG_DW = 32;

	localparam logic [STOP_NUM-1:0][COLOR_W-1:0] STOP_RESET = {
		32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
		32'hFF00_00FF, 32'hFF00_FF00, 32'hFFFF_0000
	};
	localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(3);
	localparam logic [RES_W-1:0] RES_RESET = RES_W'(256);

	typedef enum logic [2:0] {
		REG_STOP0      = 3'd0,
		REG_STOP1      = 3'd1,
		REG_STOP2      = 3'd2,
		REG_STOP3      = 3'd3,
		REG_STOP4      = 3'd4,
		REG_STOP5      = 3'd5,
		REG_STOP_COUNT = 3'd6,
		REG_TABLE_RES  = 3'd7
	} reg_idx_t;

	// Live configuration seen by the datapath
	typedef struct packed {
		logic [STOP_NUM-1:0][COLOR_W-1:0] stop;
		logic [CNT_W-1:0]                 last;
		logic [DEN_W-1:0]                 den;
	} cfg_t;

	// Stop index division: partial remainder and quotient bits so far
	typedef struct packed {
		logic [SCL_W-1:0] rem;
		logic [IDX_W-1:0] quo;
		logic             clamped;
	} idx_t;

	// Channel division, channel 0 red, 1 green, 2 blue, 3 alpha
	typedef struct packed {
		logic [CHAN_NUM-1:0][NUM_W-1:0]  rem;
		logic [CHAN_NUM-1:0][CHAN_W-1:0] quo;
		logic                            clamped;
	} chan_t;

	// One restoring step of the stop index division
	function automatic idx_t idx_step(input idx_t x, input logic [DEN_W-1:0] den,
			input int unsigned b);
		idx_t             r;
		logic [SCL_W-1:0] d;
		logic             ge;
		r  = x;
		d  = {{(SCL_W-DEN_W){1'b0}}, den} << b;
		ge = (x.rem >= d);
		r.rem = ge ? (x.rem - d) : x.rem;
		r.quo = {x.quo[IDX_W-2:0], ge};
		return r;
	endfunction

	// One restoring step on all four channels
	function automatic chan_t chan_step(input chan_t x, input logic [DEN_W-1:0] den,
			input int unsigned b);
		chan_t            r;
		logic [NUM_W-1:0] d;
		logic             ge;
		r = x;
		d = {{(NUM_W-DEN_W){1'b0}}, den} << b;
		for (int c = 0; c < CHAN_NUM; c++) begin
			ge = (x.rem[c] >= d);
			r.rem[c] = ge ? (x.rem[c] - d) : x.rem[c];
			r.quo[c] = {x.quo[c][CHAN_W-2:0], ge};
		end
		return r;
	endfunction

endpackage

### hw/rtl/gcl_cfg_regs.sv
module gcl_cfg_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [gcl_pkg::CFG_AW-1:0] paddr,
	input  logic [gcl_pkg::CFG_DW-1:0] pwdata,
	output logic [gcl_pkg::CFG_DW-1:0] prdata,
	output logic                       pready,
	output gcl_pkg::cfg_t              cfg
);
	import gcl_pkg::*;

	logic [STOP_NUM-1:0][COLOR_W-1:0] stop_q;
	logic [CNT_W-1:0]                 cnt_q;
	logic [RES_W-1:0]                 res_q;
	reg_idx_t                         ridx;
	logic                             wr_en;
	logic [CNT_W-1:0]                 cnt_w;
	logic [RES_W-1:0]                 res_w;

	assign pready = 1'b1;
	assign ridx   = reg_idx_t'(paddr[CFG_AW-1:2]);
	assign wr_en  = psel & penable & pwrite & pready;
	assign cnt_w  = pwdata[CNT_W-1:0];
	assign res_w  = pwdata[RES_W-1:0];

	// Register writes; small counts ignored, large ones saturate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_q <= STOP_RESET;
			cnt_q  <= CNT_RESET;
			res_q  <= RES_RESET;
		end else if (wr_en) begin
			unique case (ridx)
				REG_STOP_COUNT: begin
					if (cnt_w >= CNT_W'(2))
						cnt_q <= (cnt_w > CNT_W'(STOP_NUM)) ? CNT_W'(STOP_NUM) : cnt_w;
				end
				REG_TABLE_RES: begin
					if (res_w >= RES_W'(2))
						res_q <= (res_w > RES_W'(MAX_RES)) ? RES_W'(MAX_RES) : res_w;
				end
				REG_STOP0, REG_STOP1, REG_STOP2, REG_STOP3, REG_STOP4, REG_STOP5: begin
					stop_q[ridx[IDX_W-1:0]] <= pwdata[COLOR_W-1:0];
				end
			endcase
		end
	end

	// Read back
	always_comb begin
		unique case (ridx)
			REG_STOP_COUNT: prdata = {{(CFG_DW-CNT_W){1'b0}}, cnt_q};
			REG_TABLE_RES:  prdata = {{(CFG_DW-RES_W){1'b0}}, res_q};
			REG_STOP0, REG_STOP1, REG_STOP2, REG_STOP3, REG_STOP4, REG_STOP5:
				prdata = stop_q[ridx[IDX_W-1:0]];
		endcase
	end

	assign cfg.stop = stop_q;
	assign cfg.last = cnt_q - CNT_W'(1);
	assign cfg.den  = DEN_W'(res_q - RES_W'(1));

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q >= CNT_W'(2) && cnt_q <= CNT_W'(STOP_NUM))
		else $error("stop count out of range");
	a_res_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_q >= RES_W'(2) && res_q <= RES_W'(MAX_RES))
		else $error("table resolution out of range");
`endif

endmodule

### hw/rtl/gcl_idx_div.sv
module gcl_idx_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [gcl_pkg::DEN_W-1:0] den,
	input  logic [gcl_pkg::CNT_W-1:0] last,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  gcl_pkg::idx_t             in_data,
	output logic                      out_valid,
	input  logic                      out_ready,
	output gcl_pkg::idx_t             out_data
);
	import gcl_pkg::*;

	idx_t idx_s2, idx_s3, idx_s4;
	logic vld_s2, vld_s3, vld_s4;
	logic adv_s2, adv_s3, adv_s4;

	// A stage moves when it is empty or its successor moves
	assign adv_s4   = !vld_s4 | out_ready;
	assign adv_s3   = !vld_s3 | adv_s4;
	assign adv_s2   = !vld_s2 | adv_s3;
	assign in_ready = adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (adv_s2) vld_s2 <= in_valid;
			if (adv_s3) vld_s3 <= vld_s2;
			if (adv_s4) vld_s4 <= vld_s3;
		end
	end

	// One quotient bit per stage, most significant first
	always_ff @(posedge clk) begin
		if (adv_s2 && in_valid) idx_s2 <= idx_step(in_data, den, 2);
		if (adv_s3 && vld_s2)   idx_s3 <= idx_step(idx_s2, den, 1);
		if (adv_s4 && vld_s3)   idx_s4 <= idx_step(idx_s3, den, 0);
	end

	assign out_valid = vld_s4;
	assign out_data  = idx_s4;

`ifndef SYNTHESIS
	a_idx_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ({1'b0, out_data.quo} <= {{(IDX_W+1-CNT_W){1'b0}}, last}
			&& out_data.rem < {{(SCL_W-DEN_W){1'b0}}, den}))
		else $error("stop index division result out of range");
`endif

endmodule

### hw/rtl/gcl_chan_mix.sv
module gcl_chan_mix (
	input  logic          clk,
	input  logic          arst_n,
	input  gcl_pkg::cfg_t cfg,
	input  logic          in_valid,
	output logic          in_ready,
	input  gcl_pkg::idx_t in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output gcl_pkg::chan_t out_data
);
	import gcl_pkg::*;

	chan_t            mix_s5;
	logic             vld_s5;
	logic             adv_s5;
	logic [IDX_W-1:0] last_i;
	logic [IDX_W-1:0] lo_i;
	logic [IDX_W-1:0] hi_i;
	logic [DEN_W-1:0] rem_w;
	logic [DEN_W-1:0] inv_w;
	logic [COLOR_W-1:0] c_lo;
	logic [COLOR_W-1:0] c_hi;
	chan_t            nxt;

	assign adv_s5   = !vld_s5 | out_ready;
	assign in_ready = adv_s5;

	// Lower stop from the quotient, upper stop clamped to the last one
	always_comb begin
		last_i = IDX_W'(cfg.last);
		lo_i   = (in_data.quo > last_i) ? last_i : in_data.quo;
		hi_i   = (lo_i >= last_i) ? last_i : lo_i + IDX_W'(1);
		c_lo   = cfg.stop[lo_i];
		c_hi   = cfg.stop[hi_i];
		rem_w  = in_data.rem[DEN_W-1:0];
		inv_w  = cfg.den - rem_w;
	end

	// Weighted sums; channel order red, green, blue, alpha
	always_comb begin
		nxt.clamped = in_data.clamped;
		nxt.quo     = '0;
		nxt.rem[0] = NUM_W'(c_lo[23:16]) * NUM_W'(inv_w) + NUM_W'(c_hi[23:16]) * NUM_W'(rem_w);
		nxt.rem[1] = NUM_W'(c_lo[15:8])  * NUM_W'(inv_w) + NUM_W'(c_hi[15:8])  * NUM_W'(rem_w);
		nxt.rem[2] = NUM_W'(c_lo[7:0])   * NUM_W'(inv_w) + NUM_W'(c_hi[7:0])   * NUM_W'(rem_w);
		nxt.rem[3] = NUM_W'(c_lo[31:24]) * NUM_W'(inv_w) + NUM_W'(c_hi[31:24]) * NUM_W'(rem_w);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s5 <= 1'b0;
		else if (adv_s5)
			vld_s5 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (adv_s5 && in_valid) mix_s5 <= nxt;
	end

	assign out_valid = vld_s5;
	assign out_data  = mix_s5;

endmodule

### hw/rtl/gcl_chan_div.sv
module gcl_chan_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [gcl_pkg::DEN_W-1:0] den,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  gcl_pkg::chan_t            in_data,
	output logic                      out_valid,
	input  logic                      out_ready,
	output gcl_pkg::chan_t            out_data
);
	import gcl_pkg::*;

	chan_t chn_s6, chn_s7, chn_s8, chn_s9;
	logic  vld_s6, vld_s7, vld_s8, vld_s9;
	logic  adv_s6, adv_s7, adv_s8, adv_s9;

	assign adv_s9   = !vld_s9 | out_ready;
	assign adv_s8   = !vld_s8 | adv_s9;
	assign adv_s7   = !vld_s7 | adv_s8;
	assign adv_s6   = !vld_s6 | adv_s7;
	assign in_ready = adv_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else begin
			if (adv_s6) vld_s6 <= in_valid;
			if (adv_s7) vld_s7 <= vld_s6;
			if (adv_s8) vld_s8 <= vld_s7;
			if (adv_s9) vld_s9 <= vld_s8;
		end
	end

	// Two quotient bits per stage; the last stage is the output register
	always_ff @(posedge clk) begin
		if (adv_s6 && in_valid) chn_s6 <= chan_step(chan_step(in_data, den, 7), den, 6);
		if (adv_s7 && vld_s6)   chn_s7 <= chan_step(chan_step(chn_s6, den, 5), den, 4);
		if (adv_s8 && vld_s7)   chn_s8 <= chan_step(chan_step(chn_s7, den, 3), den, 2);
		if (adv_s9 && vld_s8)   chn_s9 <= chan_step(chan_step(chn_s8, den, 1), den, 0);
	end

	assign out_valid = vld_s9;
	assign out_data  = chn_s9;

`ifndef SYNTHESIS
	a_chan_rem: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.rem[0] < NUM_W'(den) && out_data.rem[1] < NUM_W'(den)
			&& out_data.rem[2] < NUM_W'(den) && out_data.rem[3] < NUM_W'(den)))
		else $error("channel division left remainder not below divisor");
`endif

endmodule

### hw/rtl/gradient_colormap_lerp_unit.sv
// Gradient color lookup with linear interpolation between 2 to 6 color stops.
// Input stream (s_*): one transaction per gradient position, position in
// s_tdata[11:0]. Output stream (m_*): one transaction per position, RGBA in
// m_tdata, m_tuser[0] set when the position was at or past the table
// resolution and was saturated to the last entry.
// APB port: registers 0..5 are the stop colors (alpha, red, green, blue from
// the top byte down), 6 the stop count, 7 the table resolution. Write it only
// while no transaction is in flight.
// From input acceptance to m_tvalid there is one stage for the position clamp
// and scaling, three for the stop index division (one quotient bit each), one
// for the stop select and weighting multipliers, four for the channel division
// (two quotient bits each). One position is taken every cycle while s_tready
// is high. Reset loads red, green and blue stops, a count of 3 and 256 entries,
// and empties the pipeline. When m_tready is low the output is held; stages
// behind it keep filling empty slots, and s_tready drops once no slot is free.
module gradient_colormap_lerp_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [gcl_pkg::CFG_AW-1:0] paddr,
	input  logic [gcl_pkg::CFG_DW-1:0] pwdata,
	output logic [gcl_pkg::CFG_DW-1:0] prdata,
	output logic                       pready,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [15:0]                s_tdata,  // [11:0] position
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [31:0]                m_tdata,  // red, green, blue, alpha
	output logic [0:0]                 m_tuser   // position_clamped
);
	import gcl_pkg::*;

	cfg_t             cfg;
	idx_t             idx_s1;
	logic             vld_s1;
	logic             adv_s1;
	idx_t             nxt_s1;
	logic [POS_W-1:0] pos;
	logic [POS_W-1:0] pos_c;
	logic             div_rdy;
	logic             div_vld;
	idx_t             div_out;
	logic             mix_rdy;
	logic             mix_vld;
	chan_t            mix_out;
	logic             chn_rdy;
	chan_t            chn_out;

	gcl_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Stage 1: saturate position, scale by stop spans
	assign pos    = s_tdata[POS_W-1:0];
	assign adv_s1 = !vld_s1 | div_rdy;
	assign s_tready = adv_s1;

	always_comb begin
		nxt_s1.clamped = (pos > cfg.den);
		pos_c          = nxt_s1.clamped ? cfg.den : pos;
		nxt_s1.rem     = SCL_W'(pos_c) * SCL_W'(cfg.last);
		nxt_s1.quo     = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (adv_s1)
			vld_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && s_tvalid) idx_s1 <= nxt_s1;
	end

	gcl_idx_div u_idx_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.den       (cfg.den),
		.last      (cfg.last),
		.in_valid  (vld_s1),
		.in_ready  (div_rdy),
		.in_data   (idx_s1),
		.out_valid (div_vld),
		.out_ready (mix_rdy),
		.out_data  (div_out)
	);

	gcl_chan_mix u_mix (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (div_vld),
		.in_ready  (mix_rdy),
		.in_data   (div_out),
		.out_valid (mix_vld),
		.out_ready (chn_rdy),
		.out_data  (mix_out)
	);

	gcl_chan_div u_chan_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.den       (cfg.den),
		.in_valid  (mix_vld),
		.in_ready  (chn_rdy),
		.in_data   (mix_out),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (chn_out)
	);

	assign m_tdata = chn_out.quo;
	assign m_tuser = chn_out.clamped;

`ifndef SYNTHESIS
	a_empty_out_takes_input: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled while output register empty");
`endif

endmodule
